[rtl/lans_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lans_pkg;

   localparam int MAX_NODES_DEF = 2048;
   localparam int POS_BITS_DEF  = 16;

   localparam int IDX_W      = 11;
   localparam int CNT_W      = 12;
   localparam int RAD_W      = 16;
   localparam int WGT_W      = 13;
   localparam int CAP_W      = 8;
   localparam int LOAD_W     = 16;
   localparam int COST_W     = 20;
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [COST_W-1:0] COST_MAX = 20'hFFFFF;
   localparam logic [WGT_W-1:0]  ONE_Q12  = 13'd4096;

   localparam logic [CNT_W-1:0] NODE_COUNT_RST = 12'd1500;
   localparam logic [RAD_W-1:0] RADIUS_RST     = 16'd4096;
   localparam logic [WGT_W-1:0] WEIGHT_RST     = 13'd2048;
   localparam logic [CAP_W-1:0] CAPACITY_RST   = 8'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY   = 2'd3;

   localparam logic REQ_WRITE = 1'b0;

   localparam logic [STAT_W-1:0] ST_WRITTEN     = 2'd0;
   localparam logic [STAT_W-1:0] ST_DELIVERED   = 2'd1;
   localparam logic [STAT_W-1:0] ST_FORWARDED   = 2'd2;
   localparam logic [STAT_W-1:0] ST_NO_NEIGHBOR = 2'd3;

   typedef enum logic [1:0] {
      ADDR_CUR,
      ADDR_DEST,
      ADDR_SCAN
   } lans_addr_sel_type;

   typedef enum logic [1:0] {
      RSP_WRITTEN,
      RSP_DELIVERED,
      RSP_ROUTE
   } lans_rsp_sel_type;

   typedef struct packed {
      logic              latch_req;
      logic              ram_wr;
      lans_addr_sel_type addr_sel;
      logic              ld_cur;
      logic              ld_dest;
      logic              ld_cand;
      logic              ref_dest;
      logic              sq_a;
      logic              sq_b;
      logic              k_clr;
      logic              k_inc;
      logic              sqrt_start;
      logic              mul_ld;
      logic              div_start;
      logic              div_term2;
      logic              t1_ld;
      logic              t2_ld;
      logic              cost_ld;
      logic              best_upd;
      logic              rsp_ld;
      lans_rsp_sel_type  rsp_sel;
   } lans_cmd_type;

   typedef struct packed {
      logic is_write;
      logic in_range;
      logic scan_end;
      logic skip;
      logic sqrt_busy;
      logic div_busy;
   } lans_stat_type;

endpackage

`default_nettype wire

[rtl/lans_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module lans_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/lans_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

module lans_sqrt #(
   parameter int IN_W = 33
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [IN_W-1:0]       operand,
   output logic                       busy,
   output logic [(IN_W+1)/2-1:0]      root
);

   localparam int OUT_W = (IN_W + 1) / 2;
   localparam int CW    = $clog2(OUT_W + 1);

   logic [2*OUT_W-1:0] op_ff;
   logic [OUT_W+1:0]   rem_ff;
   logic [OUT_W-1:0]   root_ff;
   logic [CW-1:0]      cnt_ff;
   logic               busy_ff;

   logic [OUT_W+1:0] rem_sh;
   logic [OUT_W+1:0] trial;
   logic             take;

   // one result bit per cycle, two operand bits shifted in
   always_comb begin
      rem_sh = {rem_ff[OUT_W-1:0], op_ff[2*OUT_W-1 -: 2]};
      trial  = {root_ff, 2'b01};
      take   = (rem_sh >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(OUT_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff   <= (2*OUT_W)'(operand);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         op_ff   <= op_ff << 2;
         rem_ff  <= take ? rem_sh - trial : rem_sh;
         root_ff <= {root_ff[OUT_W-2:0], take};
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

[rtl/lans_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module lans_div #(
   parameter int NUM_W = 30,
   parameter int DEN_W = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  busy,
   output logic [NUM_W-1:0]      quot
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff;
   logic [DEN_W:0]   rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;

   logic [DEN_W:0] rem_sh;
   logic           ge;

   always_comb begin
      rem_sh = {rem_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      ge     = (rem_sh >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // numerator shifts out at the top while quotient bits shift in below
   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[NUM_W-2:0], ge};
         rem_ff <= ge ? rem_sh - {1'b0, den_ff} : rem_sh;
      end
   end

   assign busy = busy_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

[rtl/lans_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module lans_datapath import lans_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEF,
   parameter int POS_BITS  = POS_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_type,
   input  wire logic [IDX_W-1:0]      req_node_index,
   input  wire logic [IDX_W-1:0]      req_dest_index,
   input  wire logic [POS_BITS-1:0]   req_pos_x,
   input  wire logic [POS_BITS-1:0]   req_pos_y,
   input  wire logic [LOAD_W-1:0]     req_queue_load,
   input  wire lans_cmd_type          cmd,
   output lans_stat_type              stat,
   output logic                       rsp_valid,
   output logic [STAT_W-1:0]          rsp_status,
   output logic [IDX_W-1:0]           rsp_next_node,
   output logic [COST_W-1:0]          rsp_best_cost
);

   localparam int ADDR_W = $clog2(MAX_NODES);
   localparam int ENT_W  = 2 * POS_BITS + LOAD_W;
   localparam int SQR_W  = 2 * POS_BITS;
   localparam int SQ_W   = SQR_W + 1;
   localparam int SAT_W  = (SQ_W > 64) ? 64 : SQ_W;
   localparam int DIST_W = (SAT_W + 1) / 2;
   localparam int RR_W   = 2 * RAD_W;
   localparam int CMP_W  = (SAT_W > RR_W) ? SAT_W : RR_W;
   localparam int P1_W   = WGT_W + DIST_W;
   localparam int P2_W   = WGT_W + LOAD_W;
   localparam int NUM_W  = (P1_W > P2_W) ? P1_W : P2_W;
   localparam int SUM_W  = NUM_W + 1;
   localparam logic [SAT_W-1:0] SAT_ONES = '1;

   // configuration registers
   logic [CNT_W-1:0] node_count_ff;
   logic [RAD_W-1:0] radius_ff;
   logic [WGT_W-1:0] weight_ff;
   logic [CAP_W-1:0] cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RST;
         radius_ff     <= RADIUS_RST;
         weight_ff     <= WEIGHT_RST;
         cap_ff        <= CAPACITY_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NODE_COUNT: node_count_ff <= csr_wdata[CNT_W-1:0];
            CSR_RADIUS:     radius_ff     <= csr_wdata[RAD_W-1:0];
            CSR_WEIGHT:     weight_ff     <= csr_wdata[WGT_W-1:0];
            CSR_CAPACITY:   cap_ff        <= csr_wdata[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   // latched transaction
   logic [IDX_W-1:0]    cur_ff, dest_ff;
   logic [POS_BITS-1:0] wx_ff, wy_ff;
   logic [LOAD_W-1:0]   wl_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         cur_ff  <= req_node_index;
         dest_ff <= req_dest_index;
         wx_ff   <= req_pos_x;
         wy_ff   <= req_pos_y;
         wl_ff   <= req_queue_load;
      end
   end

   logic cur_oob, dest_oob;
   assign cur_oob  = (32'(cur_ff) >= MAX_NODES);
   assign dest_oob = (32'(dest_ff) >= MAX_NODES);

   // node table
   logic [CNT_W-1:0]  k_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ENT_W-1:0]  rd_data;

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_CUR:  rd_addr = ADDR_W'(cur_ff);
         ADDR_DEST: rd_addr = ADDR_W'(dest_ff);
         default:   rd_addr = ADDR_W'(k_ff);
      endcase
   end

   lans_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NODES)) u_table (
      .clock (clock),
      .we    (cmd.ram_wr && !cur_oob),
      .waddr (ADDR_W'(cur_ff)),
      .wdata ({wx_ff, wy_ff, wl_ff}),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   logic [POS_BITS-1:0] rd_x, rd_y;
   logic [LOAD_W-1:0]   rd_load;
   assign rd_x    = rd_data[ENT_W-1 -: POS_BITS];
   assign rd_y    = rd_data[ENT_W-POS_BITS-1 -: POS_BITS];
   assign rd_load = rd_data[LOAD_W-1:0];

   logic [POS_BITS-1:0] cur_x_ff, cur_y_ff, dest_x_ff, dest_y_ff, cand_x_ff, cand_y_ff;
   logic [LOAD_W-1:0]   cand_load_ff;

   // an index beyond the table reads as position zero
   always_ff @(posedge clock) begin
      if (cmd.ld_cur) begin
         cur_x_ff <= cur_oob ? '0 : rd_x;
         cur_y_ff <= cur_oob ? '0 : rd_y;
      end
      if (cmd.ld_dest) begin
         dest_x_ff <= dest_oob ? '0 : rd_x;
         dest_y_ff <= dest_oob ? '0 : rd_y;
      end
      if (cmd.ld_cand) begin
         cand_x_ff    <= (cmd.ld_dest && dest_oob) ? '0 : rd_x;
         cand_y_ff    <= (cmd.ld_dest && dest_oob) ? '0 : rd_y;
         cand_load_ff <= rd_load;
      end
   end

   // squared distance, two stages
   logic [POS_BITS-1:0] ref_x, ref_y, dx, dy;
   logic [SQR_W-1:0]    sx_ff, sy_ff;
   logic [SQ_W-1:0]     sq_sum;
   logic [SAT_W-1:0]    sq_ff;
   logic [RR_W-1:0]     rr_ff;

   always_comb begin
      ref_x  = cmd.ref_dest ? dest_x_ff : cur_x_ff;
      ref_y  = cmd.ref_dest ? dest_y_ff : cur_y_ff;
      dx     = (cand_x_ff >= ref_x) ? cand_x_ff - ref_x : ref_x - cand_x_ff;
      dy     = (cand_y_ff >= ref_y) ? cand_y_ff - ref_y : ref_y - cand_y_ff;
      sq_sum = SQ_W'(sx_ff) + SQ_W'(sy_ff);
   end

   always_ff @(posedge clock) begin
      rr_ff <= RR_W'(radius_ff) * RR_W'(radius_ff);
      if (cmd.sq_a) begin
         sx_ff <= SQR_W'(dx) * SQR_W'(dx);
         sy_ff <= SQR_W'(dy) * SQR_W'(dy);
      end
      if (cmd.sq_b) begin
         sq_ff <= (sq_sum > SQ_W'(SAT_ONES)) ? SAT_ONES : SAT_W'(sq_sum);
      end
   end

   // cost terms
   logic [DIST_W-1:0] root;
   logic              sqrt_busy, div_busy;
   logic [WGT_W-1:0]  h_eff, h_rest;
   logic [RAD_W-1:0]  radius_eff, cap_eff;
   logic [P1_W-1:0]   p1_ff;
   logic [P2_W-1:0]   p2_ff;
   logic [NUM_W-1:0]  quot, t1_ff, t2_ff;
   logic [SUM_W-1:0]  cost_sum;
   logic [COST_W-1:0] cost_ff;

   lans_sqrt #(.IN_W(SAT_W)) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.sqrt_start),
      .operand (sq_ff),
      .busy    (sqrt_busy),
      .root    (root)
   );

   always_comb begin
      h_eff      = (weight_ff > ONE_Q12) ? ONE_Q12 : weight_ff;
      h_rest     = ONE_Q12 - h_eff;
      radius_eff = (radius_ff == '0) ? RAD_W'(1) : radius_ff;
      cap_eff    = (cap_ff == '0) ? RAD_W'(1) : RAD_W'(cap_ff);
      cost_sum   = SUM_W'(t1_ff) + SUM_W'(t2_ff);
   end

   lans_div #(.NUM_W(NUM_W), .DEN_W(RAD_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (cmd.div_term2 ? NUM_W'(p2_ff) : NUM_W'(p1_ff)),
      .denom (cmd.div_term2 ? cap_eff : radius_eff),
      .busy  (div_busy),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.mul_ld) begin
         p1_ff <= P1_W'(h_eff) * P1_W'(root);
         p2_ff <= P2_W'(h_rest) * P2_W'(cand_load_ff);
      end
      if (cmd.t1_ld) begin
         t1_ff <= quot;
      end
      if (cmd.t2_ld) begin
         t2_ff <= quot;
      end
      if (cmd.cost_ld) begin
         cost_ff <= (cost_sum > SUM_W'(COST_MAX)) ? COST_MAX : COST_W'(cost_sum);
      end
   end

   // scan index and running best
   logic              found_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [COST_W-1:0] best_cost_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= '0;
         found_ff <= 1'b0;
      end else if (cmd.k_clr) begin
         k_ff     <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.k_inc) begin
            k_ff <= k_ff + CNT_W'(1);
         end
         if (cmd.best_upd && (!found_ff || cost_ff < best_cost_ff)) begin
            found_ff <= 1'b1;
         end
      end
   end

   // keep the first index on a tie
   always_ff @(posedge clock) begin
      if (cmd.best_upd && (!found_ff || cost_ff < best_cost_ff)) begin
         best_cost_ff <= cost_ff;
         best_idx_ff  <= IDX_W'(k_ff);
      end
   end

   always_comb begin
      stat.is_write  = (req_type == REQ_WRITE);
      stat.in_range  = (CMP_W'(sq_ff) < CMP_W'(rr_ff));
      stat.scan_end  = (k_ff >= node_count_ff) || (32'(k_ff) >= MAX_NODES);
      stat.skip      = (k_ff == CNT_W'(cur_ff)) || (k_ff == CNT_W'(dest_ff));
      stat.sqrt_busy = sqrt_busy;
      stat.div_busy  = div_busy;
   end

   // result register
   logic              rsp_valid_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [IDX_W-1:0]  rsp_next_ff;
   logic [COST_W-1:0] rsp_cost_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_ld;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_ld) begin
         unique case (cmd.rsp_sel)
            RSP_WRITTEN: begin
               rsp_status_ff <= ST_WRITTEN;
               rsp_next_ff   <= '0;
               rsp_cost_ff   <= '0;
            end
            RSP_DELIVERED: begin
               rsp_status_ff <= ST_DELIVERED;
               rsp_next_ff   <= '0;
               rsp_cost_ff   <= '0;
            end
            default: begin
               rsp_status_ff <= found_ff ? ST_FORWARDED : ST_NO_NEIGHBOR;
               rsp_next_ff   <= found_ff ? best_idx_ff : '0;
               rsp_cost_ff   <= found_ff ? best_cost_ff : COST_MAX;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_next_node = rsp_next_ff;
   assign rsp_best_cost = rsp_cost_ff;

endmodule

`default_nettype wire

[rtl/lans_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module lans_ctrl import lans_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire lans_stat_type stat,
   output lans_cmd_type       cmd,
   output logic               busy
);

   typedef enum logic [23:0] {
      S_IDLE = 24'h000001,
      S_WRITE = 24'h000002,
      S_RCUR = 24'h000004,
      S_RDST = 24'h000008,
      S_LDST = 24'h000010,
      S_CA = 24'h000020,
      S_CB = 24'h000040,
      S_CHK = 24'h000080,
      S_SCAN = 24'h000100,
      S_SRD = 24'h000200,
      S_SA = 24'h000400,
      S_SB = 24'h000800,
      S_SC = 24'h001000,
      S_DA = 24'h002000,
      S_DB = 24'h004000,
      S_SQS = 24'h008000,
      S_SQW = 24'h010000,
      S_MUL = 24'h020000,
      S_D1S = 24'h040000,
      S_D1W = 24'h080000,
      S_D2S = 24'h100000,
      S_D2W = 24'h200000,
      S_SUM = 24'h400000,
      S_CMP = 24'h800000
   } lans_state_type;

   lans_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      cmd.addr_sel = ADDR_SCAN;
      cmd.rsp_sel  = RSP_ROUTE;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in = stat.is_write ? S_WRITE : S_RCUR;
            end
         end
         S_WRITE: begin
            cmd.ram_wr  = 1'b1;
            cmd.rsp_ld  = 1'b1;
            cmd.rsp_sel = RSP_WRITTEN;
            state_in = S_IDLE;
         end
         S_RCUR: begin
            cmd.addr_sel = ADDR_CUR;
            state_in = S_RDST;
         end
         S_RDST: begin
            cmd.addr_sel = ADDR_DEST;
            cmd.ld_cur   = 1'b1;
            state_in = S_LDST;
         end
         S_LDST: begin
            // destination doubles as the first candidate for the delivery test
            cmd.ld_dest = 1'b1;
            cmd.ld_cand = 1'b1;
            state_in = S_CA;
         end
         S_CA: begin
            cmd.sq_a = 1'b1;
            state_in = S_CB;
         end
         S_CB: begin
            cmd.sq_b = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (stat.in_range) begin
               cmd.rsp_ld  = 1'b1;
               cmd.rsp_sel = RSP_DELIVERED;
               state_in = S_IDLE;
            end else begin
               cmd.k_clr = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_end) begin
               cmd.rsp_ld = 1'b1;
               state_in = S_IDLE;
            end else if (stat.skip) begin
               cmd.k_inc = 1'b1;
            end else begin
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            cmd.ld_cand = 1'b1;
            state_in = S_SA;
         end
         S_SA: begin
            cmd.sq_a = 1'b1;
            state_in = S_SB;
         end
         S_SB: begin
            cmd.sq_b = 1'b1;
            state_in = S_SC;
         end
         S_SC: begin
            if (stat.in_range) begin
               state_in = S_DA;
            end else begin
               cmd.k_inc = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_DA: begin
            cmd.ref_dest = 1'b1;
            cmd.sq_a     = 1'b1;
            state_in = S_DB;
         end
         S_DB: begin
            cmd.sq_b = 1'b1;
            state_in = S_SQS;
         end
         S_SQS: begin
            cmd.sqrt_start = 1'b1;
            state_in = S_SQW;
         end
         S_SQW: begin
            if (!stat.sqrt_busy) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_ld = 1'b1;
            state_in = S_D1S;
         end
         S_D1S: begin
            cmd.div_start = 1'b1;
            state_in = S_D1W;
         end
         S_D1W: begin
            if (!stat.div_busy) begin
               cmd.t1_ld = 1'b1;
               state_in = S_D2S;
            end
         end
         S_D2S: begin
            cmd.div_start = 1'b1;
            cmd.div_term2 = 1'b1;
            state_in = S_D2W;
         end
         S_D2W: begin
            cmd.div_term2 = 1'b1;
            if (!stat.div_busy) begin
               cmd.t2_ld = 1'b1;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            cmd.cost_ld = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.best_upd = 1'b1;
            cmd.k_inc    = 1'b1;
            state_in = S_SCAN;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

[rtl/load_aware_next_hop_select.sv]
// Channel    Ports                                          Handshake
// request    req_type req_node_index req_dest_index         start & !busy
//            req_pos_x req_pos_y req_queue_load
// result     rsp_status rsp_next_node rsp_best_cost         rsp_valid, one cycle
// config     csr_index csr_wdata                            csr_we
//
// A write transaction stores the entry and gives its result; a query that
// delivers gives it at once after the delivery test. A forwarding query scans
// the first node_count entries (at most MAX_NODES), skipping the source and
// destination, and costs each entry in radius with the bit-serial square root
// and the shared bit-serial divider.
// Reset is synchronous; the table is not cleared. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module load_aware_next_hop_select import lans_pkg::*; #(
   parameter int MAX_NODES = MAX_NODES_DEF,
   parameter int POS_BITS  = POS_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_type,
   input  wire logic [IDX_W-1:0]      req_node_index,
   input  wire logic [IDX_W-1:0]      req_dest_index,
   input  wire logic [POS_BITS-1:0]   req_pos_x,
   input  wire logic [POS_BITS-1:0]   req_pos_y,
   input  wire logic [LOAD_W-1:0]     req_queue_load,
   output logic                       rsp_valid,
   output logic [STAT_W-1:0]          rsp_status,
   output logic [IDX_W-1:0]           rsp_next_node,
   output logic [COST_W-1:0]          rsp_best_cost
);

   lans_cmd_type  cmd;
   lans_stat_type stat;

   lans_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   lans_datapath #(.MAX_NODES(MAX_NODES), .POS_BITS(POS_BITS)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_type       (req_type),
      .req_node_index (req_node_index),
      .req_dest_index (req_dest_index),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_queue_load (req_queue_load),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_next_node  (rsp_next_node),
      .rsp_best_cost  (rsp_best_cost)
   );

endmodule

`default_nettype wire

[rtl/lans_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lans_checker import lans_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire logic [STAT_W-1:0] rsp_status,
   input wire logic [IDX_W-1:0]  rsp_next_node,
   input wire logic [COST_W-1:0] rsp_best_cost
);

   // an accepted transaction always occupies the block
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_WRITTEN || rsp_status == ST_DELIVERED)
         |-> rsp_next_node == '0 && rsp_best_cost == '0)
      else $error("write or delivery result carries a hop or cost");

   a_no_neighbor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NO_NEIGHBOR
         |-> rsp_next_node == '0 && rsp_best_cost == COST_MAX)
      else $error("no-neighbor result fields wrong");

endmodule

bind load_aware_next_hop_select lans_checker u_lans_checker (.*);

`default_nettype wire
